@@ sv/time_ordered_insert_queue_defines.svh @@
// Assertion macros for the time ordered insert queue.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef TIME_ORDERED_INSERT_QUEUE_DEFINES_SVH
`define TIME_ORDERED_INSERT_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOIQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/toiq_pkg.sv @@
// Shared types and codes of the time ordered insert queue.
// No dependencies; used by the controller and the top level.
package toiq_pkg;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [15:0] arr_time;
    logic [7:0]  pick_up;
    logic [7:0]  drop_off;
    logic [1:0]  kind;
    logic [9:0]  shelf_life;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_READ,
    ST_ENQ_CMP,
    ST_ENQ_PUT,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_POS_M1,
    RD_POS_M2
  } rd_sel_e;

  typedef struct packed {
    logic in_valid;
    logic op;
    logic full;
    logic empty;
    logic pos_zero;
    logic pos_one;
    logic key_greater;
    logic out_free;
  } ctrl_status_t;

  typedef struct packed {
    logic       in_ready;
    logic       start;
    logic       load_status;
    logic [1:0] status_val;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_en;
    logic       wr_item;
    logic       pos_dec;
    logic       finish;
  } ctrl_cmd_t;

endpackage

@@ sv/toiq_if.sv @@
// Handshake channels of the time ordered insert queue: request and response.
// Each carries valid, ready and the payload of one transaction.
interface toiq_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] in_time;
  logic [7:0]  in_pick_up;
  logic [7:0]  in_drop_off;
  logic [1:0]  in_kind;
  logic [9:0]  in_shelf_life;

  modport source (
    output valid, operation, in_time, in_pick_up, in_drop_off, in_kind, in_shelf_life,
    input  ready
  );
  modport sink (
    input  valid, operation, in_time, in_pick_up, in_drop_off, in_kind, in_shelf_life,
    output ready
  );
endinterface

interface toiq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_time;
  logic [7:0]  out_pick_up;
  logic [7:0]  out_drop_off;
  logic [1:0]  out_kind;
  logic [9:0]  out_shelf_life;
  logic [4:0]  item_count;

  modport source (
    output valid, status, out_time, out_pick_up, out_drop_off, out_kind, out_shelf_life,
           item_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_time, out_pick_up, out_drop_off, out_kind, out_shelf_life,
           item_count,
    output ready
  );
endinterface

@@ sv/toiq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module toiq_ram #(
  parameter int Width = 44,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/toiq_ctrl.sv @@
// Sequencer of the time ordered insert queue: state register, next state and commands.
// Depends on toiq_pkg.
module toiq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  toiq_pkg::ctrl_status_t status_i,
  output toiq_pkg::ctrl_cmd_t    cmd_o,
  output toiq_pkg::state_e       state_o
);
  import toiq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid) begin
          if (status_i.op == OP_ENQUEUE && !status_i.full) begin
            state_d = ST_ENQ_READ;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_ENQ_READ: begin
        state_d = status_i.pos_zero ? ST_ENQ_PUT : ST_ENQ_CMP;
      end
      ST_ENQ_CMP: begin
        if (!status_i.key_greater || status_i.pos_one) begin
          state_d = ST_ENQ_PUT;
        end
      end
      ST_ENQ_PUT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel = RD_HEAD;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready    = 1'b1;
        cmd_o.start       = status_i.in_valid;
        cmd_o.load_status = status_i.in_valid;
        if (status_i.op == OP_ENQUEUE) begin
          cmd_o.status_val = status_i.full ? STATUS_FULL : STATUS_OK;
        end else begin
          cmd_o.status_val = status_i.empty ? STATUS_EMPTY : STATUS_OK;
        end
        cmd_o.rd_en = status_i.in_valid && status_i.op == OP_DEQUEUE && !status_i.empty;
      end
      ST_ENQ_READ: begin
        cmd_o.rd_en  = !status_i.pos_zero;
        cmd_o.rd_sel = RD_POS_M1;
      end
      ST_ENQ_CMP: begin
        if (status_i.key_greater) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.pos_dec = 1'b1;
          cmd_o.rd_en   = !status_i.pos_one;
          cmd_o.rd_sel  = RD_POS_M2;
        end
      end
      ST_ENQ_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_item = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  assign state_o = state_q;

endmodule

@@ sv/time_ordered_insert_queue.sv @@
// Time ordered insert queue: entries live in a circular RAM, kept sorted from the head.
// An enqueue reads the last stored entry, then walks towards the head, shifting each stored entry
// with a later time up by one slot, and writes its item into the slot left free; the walk moves one
// entry per cycle. Dequeues and rejected transactions go straight to presenting their result.
// A new transaction is taken once the last result is presented, later while one waits unread.
// Reset empties the queue at once; the entry RAM itself is not cleared.
module time_ordered_insert_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  toiq_in_if.sink    in_i,
  toiq_out_if.source out_o
);
  import toiq_pkg::*;

  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW = CntW + 1;
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

  function automatic logic [IdxW-1:0] phys_addr(input logic [IdxW-1:0] base,
                                                input logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(QUEUE_DEPTH)) begin
      sum = sum - SumW'(QUEUE_DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  ctrl_status_t ctrl_status;
  ctrl_cmd_t    cmd;
  state_e       state;

  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            op_q;
  logic [1:0]      status_q;
  entry_t          item_q;
  logic            out_valid_q;

  logic [IdxW-1:0] rd_addr, wr_addr;
  logic [CntW-1:0] rd_off;
  entry_t          rd_data, wr_data;

  toiq_ram #(
    .Width ($bits(entry_t)),
    .Depth (QUEUE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  toiq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (ctrl_status),
    .cmd_o    (cmd),
    .state_o  (state)
  );

  always_comb begin
    ctrl_status.in_valid    = in_i.valid;
    ctrl_status.op          = in_i.operation;
    ctrl_status.full        = count_q == DepthC;
    ctrl_status.empty       = count_q == '0;
    ctrl_status.pos_zero    = pos_q == '0;
    ctrl_status.pos_one     = pos_q == CntW'(1);
    ctrl_status.key_greater = rd_data.arr_time > item_q.arr_time;
    ctrl_status.out_free    = !out_valid_q || out_o.ready;
  end

  assign in_i.ready = cmd.in_ready;

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD:   rd_off = '0;
      RD_POS_M1: rd_off = pos_q - CntW'(1);
      RD_POS_M2: rd_off = pos_q - CntW'(2);
      default:   rd_off = '0;
    endcase
  end

  assign rd_addr = phys_addr(head_q, rd_off);
  assign wr_addr = phys_addr(head_q, pos_q);
  assign wr_data = cmd.wr_item ? item_q : rd_data;

  always_comb begin
    pos_d   = pos_q;
    count_d = count_q;
    head_d  = head_q;
    if (cmd.start) begin
      pos_d = count_q;
    end else if (cmd.pos_dec) begin
      pos_d = pos_q - CntW'(1);
    end
    if (cmd.finish && status_q == STATUS_OK) begin
      if (op_q == OP_ENQUEUE) begin
        count_d = count_q + CntW'(1);
      end else begin
        count_d = count_q - CntW'(1);
        head_d  = phys_addr(head_q, CntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      head_q      <= '0;
      pos_q       <= '0;
      op_q        <= OP_ENQUEUE;
      status_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      pos_q   <= pos_d;
      if (cmd.load_status) begin
        op_q     <= in_i.operation;
        status_q <= cmd.status_val;
      end
      if (cmd.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.start) begin
      item_q.arr_time   <= in_i.in_time;
      item_q.pick_up    <= in_i.in_pick_up;
      item_q.drop_off   <= in_i.in_drop_off;
      item_q.kind       <= in_i.in_kind;
      item_q.shelf_life <= in_i.in_shelf_life;
    end
    if (cmd.finish) begin
      out_o.status     <= status_q;
      out_o.item_count <= 5'(count_d);
      if (op_q == OP_DEQUEUE && status_q == STATUS_OK) begin
        out_o.out_time       <= rd_data.arr_time;
        out_o.out_pick_up    <= rd_data.pick_up;
        out_o.out_drop_off   <= rd_data.drop_off;
        out_o.out_kind       <= rd_data.kind;
        out_o.out_shelf_life <= rd_data.shelf_life;
      end else begin
        out_o.out_time       <= '0;
        out_o.out_pick_up    <= '0;
        out_o.out_drop_off   <= '0;
        out_o.out_kind       <= '0;
        out_o.out_shelf_life <= '0;
      end
    end
  end

  assign out_o.valid = out_valid_q;

`include "time_ordered_insert_queue_defines.svh"

  `TOIQ_ASSERT_NEXT(a_count_only_at_finish, !cmd.finish, $stable(count_q), "count changed outside finish")
  `TOIQ_ASSERT_SAME(a_full_reject_when_full, cmd.finish && status_q == STATUS_FULL, count_q == DepthC, "full reject with free slots")
  `TOIQ_ASSERT_SAME(a_walk_in_range, state == ST_ENQ_CMP, pos_q != '0 && pos_q <= count_q, "insert walk out of range")
  `TOIQ_ASSERT_NEXT(a_finish_shows_result, cmd.finish, out_valid_q, "finished transaction not presented")

endmodule
